>>> src/x87rs_pkg.sv
// x87rs_pkg: widths, codes and the push-tag classifier for the x87 register stack
// no dependencies; used by the interfaces, the core, the register file and the checker
`default_nettype none

package x87rs_pkg;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned SigW     = 64;
  localparam int unsigned SeW      = 16;
  localparam int unsigned ExpW     = 15;
  localparam int unsigned TagW     = 2 * NumSlots;

  localparam logic [ExpW-1:0] ExpAllOnes = 15'h7fff;
  localparam logic [TagW-1:0] TagsAllEmpty = 16'hffff;

  typedef enum logic [1:0] {
    ActPush = 2'd0,
    ActPeek = 2'd1,
    ActPop  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TagValid   = 2'd0,
    TagZero    = 2'd1,
    TagSpecial = 2'd2,
    TagEmpty   = 2'd3
  } tag_e;

  // register file access for one transaction
  typedef struct packed {
    logic             wr_en;
    logic [SlotW-1:0] wr_slot;
    logic [SigW-1:0]  wr_sig;
    logic [SeW-1:0]   wr_se;
    logic             rd_en;
    logic [SlotW-1:0] rd_slot;
  } rf_req_t;

  function automatic tag_e classify(input logic [SigW-1:0] sig, input logic [SeW-1:0] se);
    logic [ExpW-1:0] e;
    tag_e            t;
    e = se[ExpW-1:0];
    if (e == '0 && sig == '0) begin
      t = TagZero;
    end else if (e == '0 || e == ExpAllOnes || !sig[SigW-1]) begin
      t = TagSpecial;
    end else begin
      t = TagValid;
    end
    return t;
  endfunction

  function automatic tag_e tag_of(input logic [TagW-1:0] tags, input logic [SlotW-1:0] slot);
    return tag_e'(tags[{slot, 1'b0} +: 2]);
  endfunction

endpackage

`default_nettype wire

>>> src/x87rs_if.sv
// x87rs_in_if / x87rs_out_if: valid/ready channels for operations and results
// depends on x87rs_pkg for field widths
`default_nettype none

interface x87rs_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [x87rs_pkg::SigW-1:0]    significand;
  logic [x87rs_pkg::SeW-1:0]     sign_exponent;
  logic [x87rs_pkg::SlotW-1:0]   peek_offset;

  modport source (output valid, action, significand, sign_exponent, peek_offset,
                  input ready);
  modport sink   (input valid, action, significand, sign_exponent, peek_offset,
                  output ready);
endinterface

interface x87rs_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [x87rs_pkg::SigW-1:0]    read_significand;
  logic [x87rs_pkg::SeW-1:0]     read_sign_exponent;
  logic [x87rs_pkg::SlotW-1:0]   top_of_stack;
  logic [x87rs_pkg::TagW-1:0]    tag_bits;

  modport source (output valid, status, read_significand, read_sign_exponent,
                  top_of_stack, tag_bits, input ready);
  modport sink   (input valid, status, read_significand, read_sign_exponent,
                  top_of_stack, tag_bits, output ready);
endinterface

`default_nettype wire

>>> src/x87_register_stack_with_tags_core.sv
// x87_register_stack_with_tags_core: x87 register stack with top pointer and tag word
// depends on x87rs_pkg, x87rs_if.sv and x87rs_regfile
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------------
//  in_i    | in  | valid / ready | action, significand, sign_exponent, peek_offset
//  out_o   | out | valid / ready | status, read_significand, read_sign_exponent,
//          |     |               | top_of_stack, tag_bits
//
// each transaction yields its result in the cycle after acceptance, from the registered
// read port of the register file; a new operation is taken in every cycle the result
// register is empty or being drained, so one operation per cycle is sustained
// reset clears the top pointer and the result register and marks all tags empty; the
// register file itself is never cleared, empty tags guard every read
// a stalled result holds, and the input stalls with it
`default_nettype none

module x87_register_stack_with_tags_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  x87rs_in_if.sink   in_i,
  x87rs_out_if.source out_o
);

  // architectural state, held in flops since the tag word is visible every cycle
  logic [x87rs_pkg::SlotW-1:0] top_q, top_d;
  logic [x87rs_pkg::TagW-1:0]  tags_q, tags_d;

  // result register; top and tags are shown straight from the state, which only
  // moves when the result register is loaded
  logic                out_vld_q, out_vld_d;
  x87rs_pkg::status_e  status_q, status_d;
  logic                rd_ok_q, rd_ok_d;

  logic                        accept;
  logic [x87rs_pkg::SlotW-1:0] slot;
  x87rs_pkg::tag_e             slot_tag;
  x87rs_pkg::rf_req_t          rf_req;
  logic [x87rs_pkg::SigW-1:0]  rd_sig;
  logic [x87rs_pkg::SeW-1:0]   rd_se;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // slot addressed by the operation
  always_comb begin
    case (x87rs_pkg::action_e'(in_i.action))
      x87rs_pkg::ActPush: slot = top_q - x87rs_pkg::SlotW'(1);
      x87rs_pkg::ActPeek: slot = top_q + in_i.peek_offset;
      default:            slot = top_q;
    endcase
  end

  assign slot_tag = x87rs_pkg::tag_of(tags_q, slot);

  // operation decode: state update, register file access and status
  always_comb begin
    top_d     = top_q;
    tags_d    = tags_q;
    status_d  = x87rs_pkg::StOk;
    rd_ok_d   = 1'b0;
    rf_req    = '0;
    rf_req.wr_slot = slot;
    rf_req.rd_slot = slot;
    rf_req.wr_sig  = in_i.significand;
    rf_req.wr_se   = in_i.sign_exponent;
    case (x87rs_pkg::action_e'(in_i.action))
      x87rs_pkg::ActPush: begin
        if (slot_tag != x87rs_pkg::TagEmpty) begin
          status_d = x87rs_pkg::StFull;
        end else begin
          rf_req.wr_en = accept;
          tags_d[{slot, 1'b0} +: 2] = x87rs_pkg::classify(in_i.significand, in_i.sign_exponent);
          top_d = slot;
        end
      end
      x87rs_pkg::ActPeek, x87rs_pkg::ActPop: begin
        if (slot_tag == x87rs_pkg::TagEmpty) begin
          status_d = x87rs_pkg::StEmpty;
        end else begin
          rd_ok_d      = 1'b1;
          rf_req.rd_en = accept;
          if (x87rs_pkg::action_e'(in_i.action) == x87rs_pkg::ActPop) begin
            tags_d[{slot, 1'b0} +: 2] = x87rs_pkg::TagEmpty;
            top_d = slot + x87rs_pkg::SlotW'(1);
          end
        end
      end
      default: begin
        // unused code: no change, status ok
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= '0;
      tags_q    <= x87rs_pkg::TagsAllEmpty;
      out_vld_q <= 1'b0;
      status_q  <= x87rs_pkg::StOk;
      rd_ok_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (accept) begin
        top_q    <= top_d;
        tags_q   <= tags_d;
        status_q <= status_d;
        rd_ok_q  <= rd_ok_d;
      end
    end
  end

  x87rs_regfile u_regfile (
    .clk_i    (clk_i),
    .req_i    (rf_req),
    .rd_sig_o (rd_sig),
    .rd_se_o  (rd_se)
  );

  // read fields are zero unless a peek or pop succeeded
  assign out_o.valid              = out_vld_q;
  assign out_o.status             = status_q;
  assign out_o.read_significand   = rd_ok_q ? rd_sig : '0;
  assign out_o.read_sign_exponent = rd_ok_q ? rd_se : '0;
  assign out_o.top_of_stack       = top_q;
  assign out_o.tag_bits           = tags_q;

endmodule

`default_nettype wire

>>> src/x87rs_regfile.sv
// x87rs_regfile: eight 80-bit stack registers, one write and one registered read per cycle
// depends on x87rs_pkg for widths and the request struct
`default_nettype none

module x87rs_regfile (
  input  wire logic                       clk_i,
  input  wire x87rs_pkg::rf_req_t         req_i,
  output logic [x87rs_pkg::SigW-1:0]      rd_sig_o,
  output logic [x87rs_pkg::SeW-1:0]       rd_se_o
);

  logic [x87rs_pkg::SigW+x87rs_pkg::SeW-1:0] mem_q [x87rs_pkg::NumSlots];
  logic [x87rs_pkg::SigW+x87rs_pkg::SeW-1:0] rd_q;

  // contents undefined until pushed; only tagged slots are ever read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_slot] <= {req_i.wr_se, req_i.wr_sig};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_slot];
    end
  end

  assign rd_sig_o = rd_q[x87rs_pkg::SigW-1:0];
  assign rd_se_o  = rd_q[x87rs_pkg::SigW +: x87rs_pkg::SeW];

endmodule

`default_nettype wire

>>> src/x87rs_checker.sv
// x87rs_checker: port-level checks on the x87 register stack results
// depends on x87rs_pkg; bound to x87_register_stack_with_tags_core below
`default_nettype none

module x87rs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [1:0]                  status_i,
  input wire logic [x87rs_pkg::SigW-1:0]  read_significand_i,
  input wire logic [x87rs_pkg::SeW-1:0]   read_sign_exponent_i,
  input wire logic [x87rs_pkg::SlotW-1:0] top_of_stack_i,
  input wire logic [x87rs_pkg::TagW-1:0]  tag_bits_i
);

  x87rs_pkg::tag_e top_tag;
  x87rs_pkg::tag_e below_tag;

  assign top_tag   = x87rs_pkg::tag_of(tag_bits_i, top_of_stack_i);
  assign below_tag = x87rs_pkg::tag_of(tag_bits_i, top_of_stack_i - x87rs_pkg::SlotW'(1));

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // full push leaves the slot below top occupied
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == x87rs_pkg::StFull |-> below_tag != x87rs_pkg::TagEmpty)
    else $error("full status with free slot below top");

  // failed operations return no data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == x87rs_pkg::StFull || status_i == x87rs_pkg::StEmpty)
    |-> read_significand_i == '0 && read_sign_exponent_i == '0)
    else $error("data returned by failed transaction");

  // stack stays contiguous: an empty top means an empty stack
  a_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && top_tag == x87rs_pkg::TagEmpty |-> tag_bits_i == x87rs_pkg::TagsAllEmpty)
    else $error("empty top slot over a non-empty stack");

endmodule

bind x87_register_stack_with_tags_core x87rs_checker u_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .status_i             (out_o.status),
  .read_significand_i   (out_o.read_significand),
  .read_sign_exponent_i (out_o.read_sign_exponent),
  .top_of_stack_i       (out_o.top_of_stack),
  .tag_bits_i           (out_o.tag_bits)
);

`default_nettype wire
